FILE: design/xrr_pkg.sv
// Shared constants, types and the generator step function for the xorshift range random block.
`timescale 1ns / 1ps

package xrr_pkg;

  // Width of each bound and of the result.
  localparam int unsigned BoundWidth = 32;
  // Width of the xorshift generator.
  localparam int unsigned GenWidth   = 64;
  // Width of the remainder step counter.
  localparam int unsigned CntWidth   = $clog2(GenWidth);

  // Xorshift shift amounts.
  localparam int unsigned ShiftFirst  = 26;
  localparam int unsigned ShiftSecond = 34;
  localparam int unsigned ShiftThird  = 10;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  // Status reported by the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // One xorshift step: shift left, shift right, shift left.
  function automatic logic [GenWidth-1:0] xorshift_next(input logic [GenWidth-1:0] g);
    logic [GenWidth-1:0] g1;
    logic [GenWidth-1:0] g2;
    g1 = g ^ (g << ShiftFirst);
    g2 = g1 ^ (g1 >> ShiftSecond);
    return g2 ^ (g2 << ShiftThird);
  endfunction

endpackage

FILE: design/xrr_mod_unit.sv
// Iterative restoring remainder unit: 64-bit dividend modulo the span, one bit per cycle.
`timescale 1ns / 1ps

module xrr_mod_unit
  import xrr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [GenWidth-1:0]   dividend_i,
  input  logic [BoundWidth:0]   divisor_i,
  output div_status_t           status_o,
  output logic [BoundWidth-1:0] remainder_o
);

  logic [GenWidth-1:0]   dvd_q, dvd_d;
  logic [BoundWidth:0]   span_q, span_d;
  logic [BoundWidth-1:0] rem_q, rem_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [BoundWidth:0]   trial;
  logic [BoundWidth:0]   diff;

  // One restoring step: bring in the next dividend bit and subtract the span if it fits.
  assign trial = {rem_q, dvd_q[GenWidth-1]};
  assign diff  = trial - span_q;

  always_comb begin
    dvd_d  = dvd_q;
    span_d = span_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      span_d = divisor_i;
      rem_d  = '0;
      cnt_d  = CntWidth'(GenWidth - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= span_q) begin
        rem_d = diff[BoundWidth-1:0];
      end else begin
        rem_d = trial[BoundWidth-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags need reset; the datapath registers do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign remainder_o   = rem_q;

endmodule

FILE: design/xorshift_range_random.sv
// Top level of the xorshift range random block: generator, sequencer and output register.
`timescale 1ns / 1ps

// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// request  | in_valid_i, in_ready_o, range_a_i, range_b_i | in
// result   | out_valid_o, out_ready_i, random_value_o  | out
// seed     | cfg_valid_i, cfg_ready_o, seed_value_i    | in
//
// For each request, the transfer advances the generator and loads the remainder unit, the
// one-bit-per-cycle remainder loop runs over all 64 dividend bits, and the lower bound is
// then added into the output register once it is free; only then is the next request taken.
// Reset loads the generator with 1; a seed write loads it with the seed, zero taken as 1.
// A held result does not block the next request; the sequencer waits only when a new
// result is ready while the previous one has not yet been transferred.

module xorshift_range_random
  import xrr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [GenWidth-1:0]          seed_value_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [BoundWidth-1:0] range_a_i,
  input  logic signed [BoundWidth-1:0] range_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [BoundWidth-1:0] random_value_o
);

  state_e                state_q, state_d;
  logic [GenWidth-1:0]   gen_q, gen_d;
  logic [BoundWidth-1:0] lo_q, lo_d;
  logic                  out_valid_q, out_valid_d;
  logic [BoundWidth-1:0] random_q, random_d;

  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  out_free;
  logic                  load_out;
  logic                  div_start;
  logic [GenWidth-1:0]   gen_next;
  logic signed [BoundWidth:0] a_ext;
  logic signed [BoundWidth:0] b_ext;
  logic signed [BoundWidth:0] lo_ext;
  logic signed [BoundWidth:0] hi_ext;
  logic [BoundWidth:0]   span;
  logic [BoundWidth-1:0] remainder;
  div_status_t           div_status;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Order the bounds and form the span, which is at most 2^BoundWidth.
  assign a_ext    = {range_a_i[BoundWidth-1], range_a_i};
  assign b_ext    = {range_b_i[BoundWidth-1], range_b_i};
  assign lo_ext   = (a_ext < b_ext) ? a_ext : b_ext;
  assign hi_ext   = (a_ext < b_ext) ? b_ext : a_ext;
  assign span     = unsigned'(hi_ext - lo_ext) + 1'b1;
  assign gen_next = xorshift_next(gen_q);

  assign div_start = in_xfer;

  xrr_mod_unit u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (gen_next),
    .divisor_i   (span),
    .status_o    (div_status),
    .remainder_o (remainder)
  );

  // Sequencer: next state and result load.
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Generator: a seed write takes priority, otherwise advance on each request transfer.
  always_comb begin
    gen_d = gen_q;
    if (cfg_xfer) begin
      gen_d = (seed_value_i == '0) ? GenWidth'(1) : seed_value_i;
    end else if (in_xfer) begin
      gen_d = gen_next;
    end
  end

  assign lo_d = in_xfer ? lo_ext[BoundWidth-1:0] : lo_q;

  // Output register: the result is the lower bound plus the remainder, wrapped to width.
  always_comb begin
    out_valid_d = out_valid_q;
    random_d    = random_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      random_d    = lo_q + remainder;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= GenWidth'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    random_q <= random_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = random_q;

  // The generator never reaches the all-zero lock-up state.
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("generator reached zero");

  // A request transfer starts the remainder unit on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> div_status.busy)
    else $error("remainder unit not busy after request transfer");

  // The block only accepts requests while the remainder unit is quiet.
  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_status.busy)
    else $error("request ready while remainder unit busy");

  // A new result appears only after a finished remainder computation.
  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == ST_DIV || state_q == ST_OUT) && !div_status.busy)
    else $error("result loaded without finished remainder");

endmodule

FILE: dv/xrr_checker.sv
// Checker for the xorshift range random block: tracks the generator and compares each result.
`timescale 1ns / 1ps

module xrr_checker
  import xrr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [GenWidth-1:0]          seed_value_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [BoundWidth-1:0] range_a_i,
  input  logic signed [BoundWidth-1:0] range_b_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [BoundWidth-1:0] random_value_i,
  output int                           mismatches_o,
  output int                           outstanding_o
);

  // Local copy of the generator and the queue of numbers still to come out.
  logic [GenWidth-1:0]          gen_state;
  logic signed [BoundWidth-1:0] expected_values[$];
  int                           mismatch_count;

  // One generator step: xor in the value shifted left 26, right 34, then left 10.
  function automatic logic [GenWidth-1:0] xorshift_advance(input logic [GenWidth-1:0] g);
    logic [GenWidth-1:0] s;
    s = g ^ (g << 26);
    s = s ^ (s >> 34);
    return s ^ (s << 10);
  endfunction

  // Reduce the generator value into the inclusive range spanned by the two bounds.
  function automatic logic signed [BoundWidth-1:0] pick_in_range(
    input logic [GenWidth-1:0]          g,
    input logic signed [BoundWidth-1:0] a,
    input logic signed [BoundWidth-1:0] b
  );
    longint              lo;
    longint              hi;
    logic [GenWidth-1:0] span;
    logic [GenWidth-1:0] offset;
    logic [GenWidth-1:0] total;
    lo     = (a < b) ? a : b;
    hi     = (a < b) ? b : a;
    span   = GenWidth'(hi - lo) + 64'd1;
    offset = g % span;
    total  = GenWidth'(lo) + offset;
    return total[BoundWidth-1:0];
  endfunction

  // Count a mismatch; only the first ten are printed.
  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: mismatch: %s", $realtime, what);
    end
  endtask

  // Follow every transfer: seed writes reload the generator, requests queue a number,
  // and results are compared in order.
  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [BoundWidth-1:0] want;
    if (!rst_ni) begin
      gen_state = 64'd1;
      expected_values.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        // A zero seed would lock the generator, so it is taken as one.
        gen_state = (seed_value_i == '0) ? 64'd1 : seed_value_i;
      end
      if (in_valid_i && in_ready_i) begin
        gen_state = xorshift_advance(gen_state);
        expected_values.push_back(pick_in_range(gen_state, range_a_i, range_b_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_values.size() == 0) begin
          log_mismatch($sformatf("result %0d with nothing expected", random_value_i));
        end else begin
          want = expected_values.pop_front();
          if (want !== random_value_i) begin
            log_mismatch($sformatf("random_value expected %0d actual %0d",
                                   want, random_value_i));
          end
        end
      end
    end
    mismatches_o  <= mismatch_count;
    outstanding_o <= expected_values.size();
  end

endmodule

FILE: dv/xorshift_range_random_tb.sv
// Testbench top for the xorshift range random block: stimulus, seed writes and verdict.
`timescale 1ns / 1ps

module xorshift_range_random_tb;
  import xrr_pkg::*;

  localparam logic signed [BoundWidth-1:0] BoundMax = {1'b0, {(BoundWidth-1){1'b1}}};
  localparam logic signed [BoundWidth-1:0] BoundMin = {1'b1, {(BoundWidth-1){1'b0}}};
  localparam int PhaseCount = 7;
  localparam int PhaseItems = 200;

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [GenWidth-1:0]          seed_value   = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic signed [BoundWidth-1:0] range_a      = '0;
  logic signed [BoundWidth-1:0] range_b      = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic signed [BoundWidth-1:0] random_value;
  int                           mismatches;
  int                           outstanding;
  logic                         quiet_tail   = 1'b0;

  xorshift_range_random dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .seed_value_i   (seed_value),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .range_a_i      (range_a),
    .range_b_i      (range_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .random_value_o (random_value)
  );

  xrr_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .seed_value_i   (seed_value),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .range_a_i      (range_a),
    .range_b_i      (range_b),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .random_value_i (random_value),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #2_000_000;
    $display("xorshift_range_random_tb: errors");
    $finish;
  end

  // Result side: random stalls in bursts, always ready in the tail.
  initial begin
    forever begin
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until its transfer; valid stays high afterwards.
  task automatic send_pair(input logic signed [BoundWidth-1:0] a,
                           input logic signed [BoundWidth-1:0] b);
    in_valid <= 1'b1;
    range_a  <= a;
    range_b  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and let the given number of cycles pass.
  task automatic rest(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every queued number has come out.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the seed register once the block is idle.
  task automatic load_seed(input logic [GenWidth-1:0] value);
    drain();
    cfg_valid  <= 1'b1;
    seed_value <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Draw a bound pair from a mix of wide, narrow, equal and extreme ranges.
  task automatic draw_bounds(output logic signed [BoundWidth-1:0] a,
                             output logic signed [BoundWidth-1:0] b);
    logic signed [BoundWidth-1:0] corners[5];
    int                           mode;
    corners = '{BoundMin, BoundMax, '0, -1, 1};
    mode    = $urandom_range(0, 9);
    a       = $urandom();
    b       = $urandom();
    case (mode)
      4, 5: begin
        b = a + $urandom_range(0, 255);
        if ($urandom_range(0, 1) != 0) {a, b} = {b, a};
      end
      6: begin
        b = a;
      end
      7: begin
        a = corners[$urandom_range(0, 4)];
        b = corners[$urandom_range(0, 4)];
      end
      8: begin
        b = corners[$urandom_range(0, 4)];
      end
      9: begin
        a = $signed($urandom_range(0, 32)) - 16;
        b = $signed($urandom_range(0, 32)) - 16;
      end
      default: begin
      end
    endcase
  endtask

  // Main sequence: reset, directed corners, seed extremes, random phases, verdict.
  initial begin : stimulus
    logic signed [BoundWidth-1:0] a;
    logic signed [BoundWidth-1:0] b;
    logic [GenWidth-1:0]          seed;
    int                           idle_pct;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners on the reset seed.
    send_pair('0, '0);
    send_pair(BoundMax, BoundMax);
    send_pair(BoundMin, BoundMin);
    send_pair(BoundMin, BoundMax);
    send_pair(BoundMax, BoundMin);
    send_pair(-1, 0);
    send_pair(5, -5);
    rest(3);
    send_pair(100, 1);
    send_pair(1, 100);
    send_pair(-7, -7);
    send_pair(BoundMax, '0);
    send_pair('0, BoundMin);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);

    // A zero seed is taken as one.
    load_seed('0);
    send_pair(0, 9);
    send_pair(BoundMin, BoundMax);
    send_pair(-3, -3);

    // All-ones seed.
    load_seed('1);
    send_pair(BoundMax, BoundMin);
    send_pair(0, 1);
    send_pair(-1000, 1000);

    // Random phases, each on a fresh seed; the last one runs without idling.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 2) begin
        seed = 64'h8000_0000_0000_0000;
      end else if (phase == 4) begin
        seed = 64'd1;
      end else begin
        seed = {$urandom(), $urandom()};
      end
      load_seed(seed);
      if (phase == PhaseCount - 1) quiet_tail = 1'b1;
      idle_pct = (quiet_tail || phase == 3) ? 0 : 25;
      for (int n = 0; n < PhaseItems; n++) begin
        draw_bounds(a, b);
        send_pair(a, b);
        if ($urandom_range(1, 100) <= idle_pct) rest($urandom_range(1, 13));
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("xorshift_range_random_tb: clean");
    end else begin
      $display("xorshift_range_random_tb: errors");
    end
    $finish;
  end

endmodule

FILE: xorshift_range_random.f
design/xrr_pkg.sv
design/xrr_mod_unit.sv
design/xorshift_range_random.sv
dv/xrr_checker.sv
dv/xorshift_range_random_tb.sv
